/* src/multi_producer_ring_reserve_commit_assert.svh */
// ----------------------------------------------------------------------------
// Ring reserve/commit assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_PRODUCER_RING_RESERVE_COMMIT_ASSERT_SVH
`define MULTI_PRODUCER_RING_RESERVE_COMMIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MPRRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring index assertion failed");

// next-cycle implication
`define MPRRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring index assertion failed");

`else

`define MPRRC_ASSERT_IMP(lbl, ante, cons)
`define MPRRC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* src/mprrc_pkg.sv */
// ----------------------------------------------------------------------------
// mprrc_pkg
// Operation and status codes of the ring reserve/commit index manager.
// ----------------------------------------------------------------------------
package mprrc_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_READ    = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_WR_FULL   = 2'd2,
    ST_NO_WRITER = 2'd3
  } status_t;

endpackage

/* src/multi_producer_ring_reserve_commit.sv */
// ----------------------------------------------------------------------------
// multi_producer_ring_reserve_commit
// Index manager for a ring shared by many producers and a single consumer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request beat per handshake; in_tuser = operation (reserve,
//            commit, read, peek), in_tdata = requested byte count.
//   out_*  : one result beat per request; out_tuser = status, out_tdata =
//            offset, granted, first_len, wrapped_len.
//   cfg_*  : cfg_we writes the requested ring size; capacity becomes the
//            largest power of two not above it and all indices clear.
//            Write only while no request is in flight.
//   out_tvalid rises once an accepted request has passed through the input
//   register and the index logic has loaded the result register. Throughput
//   is one request per cycle while out_tready does not hold the result
//   register, since the index registers update as each request advances.
//   When out_tready is low the result register holds and one more request
//   is still taken into the input register; after that in_tready drops.
//   Reset clears the indices, the writer count and the capacity (zero
//   capacity grants only zero-size reserves).
`include "multi_producer_ring_reserve_commit_assert.svh"

module multi_producer_ring_reserve_commit #(
  parameter int SIZE_BITS   = 16,
  parameter int WRITER_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // slave side
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((SIZE_BITS+7)/8)*8-1:0] in_tdata,   // [req_size]
  input  logic [mprrc_pkg::OP_W-1:0]    in_tuser,   // [operation]
  // master side
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [offset, granted, first_len, wrapped_len]
  output logic [((4*SIZE_BITS-1+7)/8)*8-1:0] out_tdata,
  output logic [mprrc_pkg::STATUS_W-1:0] out_tuser, // [status]
  // configuration
  input  logic                          cfg_we,
  input  logic [SIZE_BITS-1:0]          cfg_wdata
);
  import mprrc_pkg::*;

  localparam int IDX_W  = SIZE_BITS + 1;
  localparam int OFF_W  = SIZE_BITS - 1;
  localparam int OUT_W  = ((4*SIZE_BITS-1+7)/8)*8;
  localparam int PAD_W  = OUT_W - (4*SIZE_BITS-1);

  // capacity and masks
  logic [SIZE_BITS-1:0] cap_r, cap_nxt;
  logic [OFF_W-1:0]     smask_r, smask_nxt;
  logic [IDX_W-1:0]     bmask_r, bmask_nxt;

  // ring state
  logic [IDX_W-1:0]       ri_r, ri_nxt;
  logic [IDX_W-1:0]       vwi_r, vwi_nxt;
  logic [IDX_W-1:0]       rt_r, rt_nxt;
  logic [WRITER_BITS-1:0] ow_r, ow_nxt;

  // input register
  logic                 s1_valid_r;
  op_t                  op_r;
  logic [SIZE_BITS-1:0] req_r;

  // result register
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [OFF_W-1:0]     offset_r, offset_nxt;
  logic [SIZE_BITS-1:0] granted_r, granted_nxt;
  logic [SIZE_BITS-1:0] first_r, first_nxt;
  logic [SIZE_BITS-1:0] wrapped_r, wrapped_nxt;

  logic s1_advance;
  logic in_beat;

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_beat    = in_tvalid && in_tready;

  // largest power of two: smear the leading one down, keep the top bit
  logic [SIZE_BITS-1:0] smear;
  logic [SIZE_BITS-1:0] pow2;
  logic [IDX_W-1:0]     pow2_dbl;

  always_comb begin
    smear = cfg_wdata;
    for (int k = 1; k < SIZE_BITS; k = k * 2) begin
      smear = smear | (smear >> k);
    end
    pow2     = smear & ~(smear >> 1);
    pow2_dbl = {pow2, 1'b0};
    cap_nxt  = pow2;
    if (pow2 == '0) begin
      smask_nxt = '0;
      bmask_nxt = '0;
    end else begin
      smask_nxt = OFF_W'(pow2 - SIZE_BITS'(1));
      bmask_nxt = pow2_dbl - IDX_W'(1);
    end
  end

  // index arithmetic
  logic [IDX_W-1:0] cap_x, req_x, used_rsv, free_x, used_vis, read_n;
  logic [IDX_W-1:0] reg_idx, reg_n, off_x, sum_x, first_x, wrapped_x;
  logic             wr_full;

  always_comb begin
    cap_x    = {1'b0, cap_r};
    req_x    = {1'b0, req_r};
    used_rsv = (rt_r - ri_r) & bmask_r;
    free_x   = (used_rsv > cap_x) ? '0 : cap_x - used_rsv;
    used_vis = (vwi_r - ri_r) & bmask_r;
    read_n   = (req_x < used_vis) ? req_x : used_vis;
    wr_full  = &ow_r;

    reg_idx = (op_r == OP_RESERVE) ? rt_r : ri_r;
    priority if (op_r == OP_RESERVE) begin
      reg_n = req_x;
    end else if (op_r == OP_READ) begin
      reg_n = read_n;
    end else begin
      reg_n = used_vis;
    end
    off_x     = reg_idx & {2'b00, smask_r};
    sum_x     = off_x + reg_n;
    first_x   = (sum_x > cap_x) ? cap_x - off_x : reg_n;
    wrapped_x = reg_n - first_x;
  end

  always_comb begin
    ri_nxt      = ri_r;
    vwi_nxt     = vwi_r;
    rt_nxt      = rt_r;
    ow_nxt      = ow_r;
    status_nxt  = ST_OK;
    offset_nxt  = '0;
    granted_nxt = '0;
    first_nxt   = '0;
    wrapped_nxt = '0;
    unique case (op_r)
      OP_RESERVE: begin
        priority if (wr_full) begin
          status_nxt = ST_WR_FULL;
        end else if (req_x > free_x) begin
          status_nxt = ST_NO_SPACE;
        end else begin
          offset_nxt  = off_x[OFF_W-1:0];
          granted_nxt = req_r;
          first_nxt   = first_x[SIZE_BITS-1:0];
          wrapped_nxt = wrapped_x[SIZE_BITS-1:0];
          rt_nxt      = (rt_r + req_x) & bmask_r;
          ow_nxt      = ow_r + WRITER_BITS'(1);
        end
      end
      OP_COMMIT: begin
        if (ow_r == '0) begin
          status_nxt = ST_NO_WRITER;
        end else begin
          ow_nxt = ow_r - WRITER_BITS'(1);
          // last writer out publishes the reserved tail
          if (ow_r == WRITER_BITS'(1)) begin
            vwi_nxt = rt_r;
          end
        end
      end
      OP_READ: begin
        offset_nxt  = off_x[OFF_W-1:0];
        granted_nxt = read_n[SIZE_BITS-1:0];
        first_nxt   = first_x[SIZE_BITS-1:0];
        wrapped_nxt = wrapped_x[SIZE_BITS-1:0];
        ri_nxt      = (ri_r + read_n) & bmask_r;
      end
      OP_PEEK: begin
        offset_nxt  = off_x[OFF_W-1:0];
        granted_nxt = first_x[SIZE_BITS-1:0];
        first_nxt   = first_x[SIZE_BITS-1:0];
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      smask_r     <= '0;
      bmask_r     <= '0;
      ri_r        <= '0;
      vwi_r       <= '0;
      rt_r        <= '0;
      ow_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r   <= cap_nxt;
        smask_r <= smask_nxt;
        bmask_r <= bmask_nxt;
        ri_r    <= '0;
        vwi_r   <= '0;
        rt_r    <= '0;
        ow_r    <= '0;
      end else if (s1_valid_r && s1_advance) begin
        ri_r  <= ri_nxt;
        vwi_r <= vwi_nxt;
        rt_r  <= rt_nxt;
        ow_r  <= ow_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r  <= op_t'(in_tuser);
      req_r <= in_tdata[SIZE_BITS-1:0];
    end
    if (s1_valid_r && s1_advance) begin
      status_r  <= status_nxt;
      offset_r  <= offset_nxt;
      granted_r <= granted_nxt;
      first_r   <= first_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, wrapped_r, first_r, granted_r, offset_r};

  // reserved region never exceeds capacity
  `MPRRC_ASSERT_IMP(a_rsv_bound, 1'b1, (((rt_r - ri_r) & bmask_r) <= {1'b0, cap_r}))
  // visible tail lies between read index and reserved tail
  `MPRRC_ASSERT_IMP(a_vis_order, 1'b1,
    (((vwi_r - ri_r) & bmask_r) <= ((rt_r - ri_r) & bmask_r)))
  // with no writer outstanding everything reserved is visible
  `MPRRC_ASSERT_IMP(a_idle_visible, (ow_r == '0), (vwi_r == rt_r))
  // a failed request grants nothing
  `MPRRC_ASSERT_IMP(a_fail_zero, (out_valid_r && (status_r != ST_OK)),
    ((granted_r == '0) && (first_r == '0) && (wrapped_r == '0) && (offset_r == '0)))

endmodule

/* tb/sv/tb_multi_producer_ring_reserve_commit.sv */
// ----------------------------------------------------------------------------
// tb_multi_producer_ring_reserve_commit
// Self-checking bench for the ring reserve/commit index manager. A queue of
// request beats feeds a clocked driver. Each accepted request runs through
// a local model of the ring indices, and the expected result is queued.
// A clocked monitor compares every result beat field by field. Phases:
// directed corner cases, a writer-count saturation burst with one long
// receiver hold-off, then random traffic over several ring sizes.
// ----------------------------------------------------------------------------
module tb_multi_producer_ring_reserve_commit;
  import mprrc_pkg::*;

  typedef struct {
    op_t         op;
    logic [15:0] size;
  } ring_req_t;

  typedef struct {
    status_t     status;
    logic [14:0] offset;
    logic [15:0] granted;
    logic [15:0] first_len;
    logic [15:0] wrapped_len;
  } ring_res_t;

  localparam int unsigned WRITERS_MAX = 255;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [req_size]
  logic [1:0]  in_tuser;   // [operation]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [offset, granted, first_len, wrapped_len]
  logic [1:0]  out_tuser;  // [status]
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  // model of the ring indices
  int unsigned ring_cap;
  int unsigned rd_idx;
  int unsigned vis_idx;
  int unsigned rsv_tail;
  int unsigned writers;

  ring_req_t   ring_req_q[$];
  ring_res_t   ring_expect_q[$];
  ring_req_t   next_req;
  ring_res_t   want;
  int          req_issued;
  int          req_count;
  int          res_count;
  int          err_count;
  int          cfg_writes;
  int          status_seen[4];
  int          send_idle;
  int          recv_idle;
  int          hold_left;
  logic        hold_done;

  multi_producer_ring_reserve_commit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void ring_set_capacity(logic [15:0] v);
    ring_cap = 0;
    for (int b = 15; b >= 0; b--) begin
      if (v[b]) begin
        ring_cap = 1 << b;
        break;
      end
    end
    rd_idx   = 0;
    vis_idx  = 0;
    rsv_tail = 0;
    writers  = 0;
  endfunction

  // split a region of n bytes at idx around the ring end
  function automatic ring_res_t ring_region(int unsigned idx, int unsigned n);
    ring_res_t   r;
    int unsigned off;
    int unsigned first;
    off   = idx & (ring_cap != 0 ? ring_cap - 1 : 0);
    first = n;
    if (off + n > ring_cap) first = ring_cap - off;
    r.status      = ST_OK;
    r.offset      = 15'(off);
    r.granted     = 16'(n);
    r.first_len   = 16'(first);
    r.wrapped_len = 16'(n - first);
    return r;
  endfunction

  function automatic ring_res_t ring_predict(op_t op, logic [15:0] req);
    ring_res_t   r;
    int unsigned bm;
    int unsigned used;
    int unsigned room;
    int unsigned n;
    int unsigned off;
    bm            = ring_cap != 0 ? 2 * ring_cap - 1 : 0;
    r.status      = ST_OK;
    r.offset      = '0;
    r.granted     = '0;
    r.first_len   = '0;
    r.wrapped_len = '0;
    case (op)
      OP_RESERVE: begin
        used = (rsv_tail - rd_idx) & bm;
        room = used > ring_cap ? 0 : ring_cap - used;
        if (writers >= WRITERS_MAX) begin
          r.status = ST_WR_FULL;
        end else if (req > room) begin
          r.status = ST_NO_SPACE;
        end else begin
          r        = ring_region(rsv_tail, req);
          rsv_tail = (rsv_tail + req) & bm;
          writers++;
        end
      end
      OP_COMMIT: begin
        if (writers == 0) begin
          r.status = ST_NO_WRITER;
        end else begin
          writers--;
          if (writers == 0) vis_idx = rsv_tail;
        end
      end
      OP_READ: begin
        used   = (vis_idx - rd_idx) & bm;
        n      = req < used ? req : used;
        r      = ring_region(rd_idx, n);
        rd_idx = (rd_idx + n) & bm;
      end
      default: begin
        used = (vis_idx - rd_idx) & bm;
        off  = rd_idx & (ring_cap != 0 ? ring_cap - 1 : 0);
        n    = used;
        if (off + n > ring_cap) n = ring_cap - off;
        r.offset    = 15'(off);
        r.granted   = 16'(n);
        r.first_len = 16'(n);
      end
    endcase
    return r;
  endfunction

  task automatic ring_report(string what, int unsigned got, int unsigned exp_val);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
             what, got, exp_val, res_count, $time);
    err_count++;
  endtask

  task automatic ring_push(op_t op, logic [15:0] sz);
    ring_req_t r;
    r.op   = op;
    r.size = sz;
    ring_req_q.push_back(r);
    req_issued++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_idle = 23; recv_idle = 51; end
      1: begin send_idle = 51; recv_idle = 23; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
  endtask

  // wait until every request is accepted and answered, then let the pipe settle
  task automatic drain_results();
    int guard;
    guard = 0;
    while ((req_count != req_issued || ring_expect_q.size() != 0) && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic ring_configure(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_set_capacity(v);
    cfg_writes++;
  endtask

  // mostly reserve/commit/read cycles sized to the ring, some oversized noise
  task automatic ring_random_phase(int n);
    op_t         op;
    logic [15:0] sz;
    int          pick;
    int unsigned lim;
    lim = ring_cap == 0 ? 4 : (ring_cap > 2 ? ring_cap / 2 : ring_cap);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 38) op = OP_RESERVE;
      else if (pick < 70) op = OP_COMMIT;
      else if (pick < 90) op = OP_READ;
      else op = OP_PEEK;
      pick = $urandom_range(9);
      if (pick < 7) sz = 16'($urandom_range(lim, 0));
      else if (pick < 9) sz = 16'($urandom_range(65535, 0));
      else sz = 16'hFFFF;
      ring_push(op, sz);
    end
  endtask

  // driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ring_expect_q.push_back(ring_predict(op_t'(in_tuser), in_tdata));
        req_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (ring_req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_req = ring_req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_req.op;
          in_tdata  <= next_req.size;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, early in the saturation burst
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_count >= 120) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        res_count++;
        status_seen[out_tuser]++;
        if (ring_expect_q.size() == 0) begin
          ring_report("result with nothing expected, status", out_tuser, 0);
        end else begin
          want = ring_expect_q.pop_front();
          if (out_tuser != want.status) ring_report("status", out_tuser, want.status);
          if (out_tdata[14:0] != want.offset)
            ring_report("offset", out_tdata[14:0], want.offset);
          if (out_tdata[30:15] != want.granted)
            ring_report("granted", out_tdata[30:15], want.granted);
          if (out_tdata[46:31] != want.first_len)
            ring_report("first_len", out_tdata[46:31], want.first_len);
          if (out_tdata[62:47] != want.wrapped_len)
            ring_report("wrapped_len", out_tdata[62:47], want.wrapped_len);
          if (out_tdata[63] != 1'b0) ring_report("pad bit", out_tdata[63], 0);
        end
      end
      if (hold_left != 0) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    logic [15:0] sizes[6];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    req_issued = 0;
    req_count  = 0;
    res_count  = 0;
    err_count  = 0;
    cfg_writes = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    ring_set_capacity(16'd0);
    set_idle(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero capacity out of reset: only zero-size reserves succeed
    ring_push(OP_RESERVE, 16'd0);
    ring_push(OP_RESERVE, 16'd1);
    ring_push(OP_RESERVE, 16'hFFFF);
    ring_push(OP_READ, 16'hFFFF);
    ring_push(OP_PEEK, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    drain_results();
    ring_configure(16'd0);

    // 16-byte ring: fill, invisible until last commit, wrap on reserve and read
    ring_configure(16'h0013);
    ring_push(OP_RESERVE, 16'd10);
    ring_push(OP_RESERVE, 16'd6);
    ring_push(OP_RESERVE, 16'd1);
    ring_push(OP_READ, 16'd4);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_PEEK, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_PEEK, 16'd0);
    ring_push(OP_READ, 16'd10);
    ring_push(OP_RESERVE, 16'd10);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_PEEK, 16'd0);
    ring_push(OP_READ, 16'hFFFF);
    ring_push(OP_READ, 16'd5);
    ring_push(OP_RESERVE, 16'd16);
    ring_push(OP_RESERVE, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_RESERVE, 16'hFFFF);
    drain_results();

    // largest ring, then saturate the writer count and unwind it
    ring_configure(16'hFFFF);
    ring_push(OP_RESERVE, 16'h8000);
    ring_push(OP_COMMIT, 16'd0);
    ring_push(OP_READ, 16'hFFFF);
    for (int i = 0; i < 257; i++) ring_push(OP_RESERVE, 16'($urandom_range(3, 0)));
    for (int i = 0; i < 257; i++) ring_push(OP_COMMIT, 16'($urandom_range(65535, 0)));
    ring_push(OP_READ, 16'hFFFF);
    drain_results();

    sizes[0] = 16'd1;
    sizes[1] = 16'h8000;
    sizes[2] = 16'($urandom_range(255, 2));
    sizes[3] = 16'd0;
    sizes[4] = 16'($urandom_range(65535, 0));
    sizes[5] = 16'h0040;
    for (int p = 0; p < 6; p++) begin
      set_idle(p < 3 ? 1 : 2);
      ring_configure(sizes[p]);
      ring_random_phase(55);
      drain_results();
    end

    if (ring_expect_q.size() != 0) ring_report("results missing", ring_expect_q.size(), 0);
    $display("Ran %0d requests over %0d ring size writes, %0d results checked",
             req_count, cfg_writes, res_count);
    $display("Status mix: ok %0d, no space %0d, writers full %0d, no writer %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
